// ===== sv/ip_prefix_whitelist_match_top_macros.svh =====
// Assertion helpers for the prefix match block.
`ifndef IP_PREFIX_WHITELIST_MATCH_TOP_MACROS_SVH
`define IP_PREFIX_WHITELIST_MATCH_TOP_MACROS_SVH

// same-cycle implication
`define IPWL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipwl assertion failed");

// next-cycle implication
`define IPWL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipwl assertion failed");

`endif

// ===== sv/ipwl_pkg.sv =====
`timescale 1ns / 1ps

package ipwl_pkg;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;

    localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
    localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

    typedef struct packed {
        logic [1:0]  kind;
        logic        is_v6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  prefix_len;
    } req_t;

    typedef struct packed {
        logic       matched;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        logic        family;
        logic [7:0]  prefix;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic write;
        logic scan_init;
        logic issue;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] kind;
        logic       prefix_ok;
        logic       full;
        logic       empty;
        logic       more;
        logic       hit;
        logic       miss_end;
    } dp_stat_t;

    function automatic logic entry_covers(entry_t e, req_t k);
        logic [127:0] m6;
        logic [31:0]  m4;
        logic         hit;
        m6 = ~({128{1'b1}} >> e.prefix);
        m4 = ~(32'hffff_ffff >> e.prefix);
        if (e.family != k.is_v6)
            hit = 1'b0;
        else if (e.family)
            hit = ((({e.addr_hi, e.addr_lo}) ^ ({k.addr_hi, k.addr_lo})) & m6) == 128'd0;
        else
            hit = ((e.addr_lo[31:0] ^ k.addr_lo[31:0]) & m4) == 32'd0;
        return hit;
    endfunction

endpackage

// ===== sv/ip_prefix_whitelist_match_top.sv =====
`timescale 1ns / 1ps

// IPv4/IPv6 prefix table with clear, add and lookup words. A word is taken
// when start is high and busy is low; its single result shows on rsp for
// one cycle with done high, and the receiver cannot stall it. Clear, add and
// unused kinds answer from the decide state. A lookup walks the stored
// entries through the table memory's one read port, one entry per cycle,
// and answers on the first hit or after the last entry; on an empty table it
// answers from the decide state like the other kinds. busy drops
// in the same cycle that done is high, so the next word can be taken at the
// same edge as the result.
module ip_prefix_whitelist_match_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ipwl_pkg::req_t req,
    output logic           done,
    output ipwl_pkg::rsp_t rsp
);

    ipwl_pkg::ctl_cmd_t cmd;
    ipwl_pkg::dp_stat_t stat;

    ipwl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

    ipwl_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

// ===== sv/ipwl_ram.sv =====
`timescale 1ns / 1ps

module ipwl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ipwl_datapath.sv =====
`timescale 1ns / 1ps

module ipwl_datapath #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ipwl_pkg::req_t    req,
    input  ipwl_pkg::ctl_cmd_t cmd,
    output ipwl_pkg::dp_stat_t stat
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    ipwl_pkg::req_t   key_reg;
    ipwl_pkg::req_t   key_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    idx_next;
    logic             rv_reg;
    logic             last_reg;
    logic             last_next;
    ipwl_pkg::entry_t wr_entry;
    ipwl_pkg::entry_t rd_entry;
    logic             covers;

    // IPv4 keeps only the low 32 address bits
    always_comb
    begin
        key_next = req;
        if (!req.is_v6)
        begin
            key_next.addr_hi = 64'd0;
            key_next.addr_lo = {32'd0, req.addr_lo[31:0]};
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
            count_next = '0;
        else if (cmd.write)
            count_next = count_reg + CW'(1);
        idx_next = idx_reg;
        if (cmd.scan_init)
            idx_next = '0;
        else if (cmd.issue)
            idx_next = idx_reg + CW'(1);
        last_next = (idx_reg + CW'(1)) == count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            rv_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            rv_reg    <= cmd.issue;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= key_next;
        end
    end

    assign wr_entry.family  = key_reg.is_v6;
    assign wr_entry.prefix  = key_reg.prefix_len;
    assign wr_entry.addr_hi = key_reg.addr_hi;
    assign wr_entry.addr_lo = key_reg.addr_lo;

    ipwl_ram #(
        .WIDTH ($bits(ipwl_pkg::entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_entry),
        .re    (cmd.issue),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    assign covers = ipwl_pkg::entry_covers(rd_entry, key_reg);

    always_comb
    begin
        stat.kind = key_reg.kind;
        if (key_reg.is_v6)
            stat.prefix_ok = (key_reg.prefix_len != 8'd0) &&
                             (key_reg.prefix_len <= ipwl_pkg::V6_MAX_PREFIX);
        else
            stat.prefix_ok = (key_reg.prefix_len != 8'd0) &&
                             (key_reg.prefix_len <= ipwl_pkg::V4_MAX_PREFIX);
        stat.full     = count_reg == CW'(TABLE_ENTRIES);
        stat.empty    = count_reg == '0;
        stat.more     = idx_reg < count_reg;
        stat.hit      = rv_reg && covers;
        stat.miss_end = rv_reg && last_reg && !covers;
    end

endmodule

// ===== sv/ipwl_ctrl.sv =====
`timescale 1ns / 1ps

module ipwl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output ipwl_pkg::rsp_t     rsp,
    output ipwl_pkg::ctl_cmd_t cmd,
    input  ipwl_pkg::dp_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic           busy_reg;
    logic           busy_next;
    logic           done_reg;
    logic           done_next;
    ipwl_pkg::rsp_t rsp_reg;
    ipwl_pkg::rsp_t rsp_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        rsp_next   = '0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    busy_next  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                done_next  = 1'b1;
                busy_next  = 1'b0;
                state_next = S_IDLE;
                case (stat.kind)
                    ipwl_pkg::KIND_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    ipwl_pkg::KIND_ADD:
                    begin
                        if (!stat.prefix_ok)
                            rsp_next.status = ipwl_pkg::ST_BAD_PREFIX;
                        else if (stat.full)
                            rsp_next.status = ipwl_pkg::ST_FULL;
                        else
                            cmd.write = 1'b1;
                    end
                    ipwl_pkg::KIND_LOOKUP:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.scan_init = 1'b1;
                            done_next     = 1'b0;
                            busy_next     = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                        // unused kind: plain zero result
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.issue = stat.more;
                if (stat.hit || stat.miss_end)
                begin
                    done_next        = 1'b1;
                    busy_next        = 1'b0;
                    rsp_next.matched = stat.hit;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== sv/ipwl_checker.sv =====
`timescale 1ns / 1ps
`include "ip_prefix_whitelist_match_top_macros.svh"

module ipwl_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input ipwl_pkg::req_t req,
    input logic           done,
    input ipwl_pkg::rsp_t rsp
);

    // a taken word holds off the next one
    `IPWL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // result strobe never repeats back to back
    `IPWL_ASSERT_NEXT(a_done_pulse, done, !done)

    // no result in the cycle right after a word is taken
    `IPWL_ASSERT_NEXT(a_no_early_done, start && !busy, !done)

    // a refused add never reports a match
    `IPWL_ASSERT_NOW(a_status_no_match, done && (rsp.status != ipwl_pkg::ST_OK),
        !rsp.matched && (rsp.status == ipwl_pkg::ST_BAD_PREFIX ||
        rsp.status == ipwl_pkg::ST_FULL))

endmodule

bind ip_prefix_whitelist_match_top ipwl_checker u_ipwl_checker (.*);

// ===== test/ip_prefix_whitelist_match_checker.sv =====
`timescale 1ns / 1ps

module ip_prefix_whitelist_match_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  ipwl_pkg::req_t req,
    input  logic           done,
    input  ipwl_pkg::rsp_t rsp,
    output int             fail_count,
    output int             pending
);

    localparam int REPORT_LIMIT = 10;

    // shadow of the network table; v4 addresses sit in the low 32 bits
    logic [127:0]   net_addr [TABLE_ENTRIES];
    logic [7:0]     net_len  [TABLE_ENTRIES];
    logic           net_v6   [TABLE_ENTRIES];
    int             net_count;
    ipwl_pkg::rsp_t awaited_rsp[$];
    int             result_index;

    function automatic logic network_covers(int i, logic v6, logic [127:0] a);
        logic [127:0] m;
        int           width;
        width = v6 ? 128 : 32;
        m = ~128'd0 << (width - int'(net_len[i]));
        if (!v6)
        begin
            m[127:32] = '0;
        end
        return (net_v6[i] == v6) && (((a ^ net_addr[i]) & m) == 128'd0);
    endfunction

    // updates the shadow table and returns the result the word should give
    function automatic ipwl_pkg::rsp_t apply_word(ipwl_pkg::req_t w);
        ipwl_pkg::rsp_t r;
        logic [127:0]   a;
        logic [7:0]     max_len;
        r = '0;
        r.status = ipwl_pkg::ST_OK;
        a = w.is_v6 ? {w.addr_hi, w.addr_lo} : {96'd0, w.addr_lo[31:0]};
        max_len = w.is_v6 ? ipwl_pkg::V6_MAX_PREFIX : ipwl_pkg::V4_MAX_PREFIX;
        case (w.kind)
            ipwl_pkg::KIND_CLEAR:
            begin
                net_count = 0;
            end
            ipwl_pkg::KIND_ADD:
            begin
                // prefix range is checked before table space
                if (w.prefix_len == 8'd0 || w.prefix_len > max_len)
                begin
                    r.status = ipwl_pkg::ST_BAD_PREFIX;
                end
                else if (net_count >= TABLE_ENTRIES)
                begin
                    r.status = ipwl_pkg::ST_FULL;
                end
                else
                begin
                    net_addr[net_count] = a;
                    net_len[net_count]  = w.prefix_len;
                    net_v6[net_count]   = w.is_v6;
                    net_count++;
                end
            end
            ipwl_pkg::KIND_LOOKUP:
            begin
                for (int i = 0; i < net_count; i++)
                begin
                    if (network_covers(i, w.is_v6, a))
                    begin
                        r.matched = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ipwl_pkg::rsp_t want;
        if (!rst_n)
        begin
            net_count = 0;
            awaited_rsp.delete();
            fail_count = 0;
            pending = 0;
            result_index = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("result %0d with no word pending: matched=%0d status=%0d",
                                 result_index, rsp.matched, rsp.status);
                    end
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.matched !== want.matched || rsp.status !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display({"result %0d mismatch: expected matched=%0d ",
                                      "status=%0d, got matched=%0d status=%0d"},
                                     result_index, want.matched, want.status,
                                     rsp.matched, rsp.status);
                        end
                    end
                end
                result_index++;
            end
            if (start && !busy)
            begin
                awaited_rsp.push_back(apply_word(req));
            end
            pending = awaited_rsp.size();
        end
    end

endmodule

// ===== test/ip_prefix_whitelist_match_top_test.sv =====
`timescale 1ns / 1ps

module ip_prefix_whitelist_match_top_test;

    localparam int         TABLE_ENTRIES  = 16;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam int         WORD_TARGET    = 1050;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 40;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           start;
    logic           busy;
    ipwl_pkg::req_t req;
    logic           done;
    ipwl_pkg::rsp_t rsp;
    int             fail_count;
    int             pending;
    int             words_sent;
    int             idle_pct;
    ipwl_pkg::req_t added_q[$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    ip_prefix_whitelist_match_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    ip_prefix_whitelist_match_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic ipwl_pkg::req_t make_word(logic [1:0] kind, logic v6,
                                                 logic [63:0] hi, logic [63:0] lo,
                                                 logic [7:0] len);
        ipwl_pkg::req_t w;
        w.kind       = kind;
        w.is_v6      = v6;
        w.addr_hi    = hi;
        w.addr_lo    = lo;
        w.prefix_len = len;
        return w;
    endfunction

    // mostly legal lengths, with the edges and some out-of-range ones
    function automatic logic [7:0] pick_prefix(logic v6);
        logic [7:0] max_len;
        int         r;
        max_len = v6 ? ipwl_pkg::V6_MAX_PREFIX : ipwl_pkg::V4_MAX_PREFIX;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 8'd0;
        if (r < 10)
            return max_len + 8'd1;
        if (r < 14)
            return 8'($urandom_range(int'(max_len) + 1, 255));
        if (r < 20)
            return max_len;
        if (r < 24)
            return 8'd1;
        return 8'($urandom_range(1, int'(max_len)));
    endfunction

    // lookup near a stored network: low bits scrambled to a random depth
    function automatic ipwl_pkg::req_t lookup_near(ipwl_pkg::req_t src);
        ipwl_pkg::req_t w;
        w = src;
        w.kind = ipwl_pkg::KIND_LOOKUP;
        w.prefix_len = 8'($urandom);
        if (src.is_v6)
        begin
            {w.addr_hi, w.addr_lo} = {src.addr_hi, src.addr_lo}
                                     ^ ({rand64(), rand64()} >> $urandom_range(0, 128));
        end
        else
        begin
            w.addr_lo[31:0]  = src.addr_lo[31:0] ^ ($urandom >> $urandom_range(0, 32));
            w.addr_lo[63:32] = $urandom;
            w.addr_hi        = rand64();
        end
        if ($urandom_range(0, 9) == 0)
        begin
            w.is_v6 = ~w.is_v6;
        end
        return w;
    endfunction

    task automatic send_word(input ipwl_pkg::req_t w);
        int gap;
        @(negedge clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (w.kind != KIND_UNUSED)
        begin
            words_sent++;
        end
    endtask

    // hold off until every outstanding result has come back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                stalled = 0;
            else
                stalled++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        ipwl_pkg::req_t w;
        int             pick;
        logic           v6;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        words_sent = 0;
        idle_pct = 33;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // empty table, then refused adds
        send_word(make_word(ipwl_pkg::KIND_CLEAR, 1'b0, '0, '0, '0));
        send_word(make_word(ipwl_pkg::KIND_LOOKUP, 1'b0, '0, '0, '0));
        send_word(make_word(ipwl_pkg::KIND_LOOKUP, 1'b1, '1, '1, '1));
        send_word(make_word(ipwl_pkg::KIND_ADD, 1'b0, '0, 64'h0000_0000_0a00_0000, 8'd0));
        send_word(make_word(ipwl_pkg::KIND_ADD, 1'b0, '0, 64'h0000_0000_0a00_0000,
                            ipwl_pkg::V4_MAX_PREFIX + 8'd1));
        send_word(make_word(ipwl_pkg::KIND_ADD, 1'b1, '1, '1, 8'd0));
        send_word(make_word(ipwl_pkg::KIND_ADD, 1'b1, '1, '1,
                            ipwl_pkg::V6_MAX_PREFIX + 8'd1));
        send_word(make_word(ipwl_pkg::KIND_ADD, 1'b1, '1, '1, 8'hff));
        // v4 with junk in the ignored upper bits
        send_word(make_word(ipwl_pkg::KIND_ADD, 1'b0, '1, 64'hffff_ffff_c0a8_0101,
                            ipwl_pkg::V4_MAX_PREFIX));
        send_word(make_word(ipwl_pkg::KIND_ADD, 1'b0, '0, '0, 8'd1));
        send_word(make_word(ipwl_pkg::KIND_ADD, 1'b1, '1, '1, ipwl_pkg::V6_MAX_PREFIX));
        send_word(make_word(ipwl_pkg::KIND_ADD, 1'b1, '0, '0, 8'd1));
        send_word(make_word(ipwl_pkg::KIND_ADD, 1'b1, 64'h2001_0db8_0000_0000, rand64(),
                            8'd64));
        send_word(make_word(ipwl_pkg::KIND_ADD, 1'b1, 64'hfe80_0000_0000_0000,
                            64'h8000_0000_0000_0000, 8'd65));
        send_word(make_word(ipwl_pkg::KIND_LOOKUP, 1'b0, '0, 64'h0000_0000_c0a8_0101, '0));
        send_word(make_word(ipwl_pkg::KIND_LOOKUP, 1'b0, '0, 64'h0000_0000_8000_0000, '0));
        send_word(make_word(ipwl_pkg::KIND_LOOKUP, 1'b0, '1, 64'hffff_ffff_7fff_ffff, '1));
        send_word(make_word(ipwl_pkg::KIND_LOOKUP, 1'b1, '1, '1, '0));
        send_word(make_word(ipwl_pkg::KIND_LOOKUP, 1'b1, '1, 64'hffff_ffff_ffff_fffe, '0));
        send_word(make_word(ipwl_pkg::KIND_LOOKUP, 1'b1, 64'hfe80_0000_0000_0000,
                            64'h8000_0000_0000_0001, '0));
        // v6 word carrying a stored v4 address: family must not match
        send_word(make_word(ipwl_pkg::KIND_LOOKUP, 1'b1, 64'h8000_0000_0000_0000,
                            64'h0000_0000_c0a8_0101, '0));
        send_word(make_word(KIND_UNUSED, 1'b1, '1, '1, '1));
        drain();

        while (words_sent < WORD_TARGET)
        begin
            if (words_sent < WORD_TARGET / 3)
                idle_pct = 33;
            else if (words_sent < 2 * WORD_TARGET / 3)
                idle_pct = 65;
            else
                idle_pct = 0;

            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_word(make_word(2'($urandom_range(0, 3)), 1'($urandom), rand64(),
                                        rand64(), 8'($urandom)));
                end
            end
            else
            begin
                if ($urandom_range(0, 99) < 75)
                begin
                    send_word(make_word(ipwl_pkg::KIND_CLEAR, 1'($urandom), rand64(),
                                        rand64(), 8'($urandom)));
                    added_q.delete();
                end
                repeat ($urandom_range(0, 20))
                begin
                    v6 = 1'($urandom);
                    w = make_word(ipwl_pkg::KIND_ADD, v6, rand64(), rand64(),
                                  pick_prefix(v6));
                    send_word(w);
                    if (added_q.size() < 64)
                    begin
                        added_q.push_back(w);
                    end
                end
                repeat ($urandom_range(1, 12))
                begin
                    if (added_q.size() != 0 && $urandom_range(0, 99) < 75)
                        w = lookup_near(added_q[$urandom_range(0, added_q.size() - 1)]);
                    else
                        w = make_word(ipwl_pkg::KIND_LOOKUP, 1'($urandom), rand64(),
                                      rand64(), 8'($urandom));
                    send_word(w);
                end
            end
            if ($urandom_range(0, 99) < 6)
            begin
                drain();
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
